// ===== rtl/dual_quadrature_odometer_macros.svh =====
// Assertion macros used by the odometer state module.
// Needs clk and arst_n in the scope of each use.
`ifndef DUAL_QUADRATURE_ODOMETER_MACROS_SVH
`define DUAL_QUADRATURE_ODOMETER_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define DQO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometer check failed");

// Next-cycle implication, inactive during reset.
`define DQO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometer check failed");

`endif

// ===== rtl/dqo_pkg.sv =====
// Shared types and constants for the dual quadrature odometer.
// No dependencies.
`timescale 1ns / 1ps

package dqo_pkg;

	localparam logic [1:0]  KIND_EDGE  = 2'd0;
	localparam logic [1:0]  KIND_TICK  = 2'd1;
	localparam logic [1:0]  KIND_CLEAR = 2'd2;

	localparam logic [15:0] GAIN_RESET = 16'd655;

	// What the distance stage does with a request
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_TICK,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       left_edge;
		logic       left_phase_a;
		logic       left_phase_b;
		logic       right_edge;
		logic       right_phase_a;
		logic       right_phase_b;
	} req_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] vel_left;
		logic [31:0] vel_right;
		logic [31:0] sum_left;
		logic [31:0] sum_right;
	} stage_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_en_t;

endpackage

// ===== rtl/dqo_state.sv =====
// Counter state of the odometer: window counts, latched speeds and pulse totals.
// Depends on dqo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_quadrature_odometer_macros.svh"

module dqo_state
	import dqo_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pipe_en_t en,
	input  req_t     req,
	output stage_t   st
);

	logic [31:0] window_left_q;
	logic [31:0] window_right_q;
	logic [31:0] speed_left_q;
	logic [31:0] speed_right_q;
	logic [31:0] sum_left_q;
	logic [31:0] sum_right_q;
	op_t         op_s1;

	logic [31:0] win_left_next;
	logic [31:0] win_right_next;
	op_t         op_next;

	logic        clear_req;
	logic        tick_req;
	logic        idle_edge_req;

	// Left counts down on A != B, right counts up on A != B
	always_comb begin
		win_left_next  = window_left_q;
		win_right_next = window_right_q;
		if (req.left_edge) begin
			if (req.left_phase_a ^ req.left_phase_b)
				win_left_next = window_left_q - 32'd1;
			else
				win_left_next = window_left_q + 32'd1;
		end
		if (req.right_edge) begin
			if (req.right_phase_a ^ req.right_phase_b)
				win_right_next = window_right_q + 32'd1;
			else
				win_right_next = window_right_q - 32'd1;
		end
	end

	always_comb begin
		case (req.kind)
			KIND_TICK:  op_next = OP_TICK;
			KIND_CLEAR: op_next = OP_CLEAR;
			default:    op_next = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_left_q  <= '0;
			window_right_q <= '0;
			speed_left_q   <= '0;
			speed_right_q  <= '0;
			sum_left_q     <= '0;
			sum_right_q    <= '0;
			op_s1          <= OP_HOLD;
		end else if (en.en1) begin
			op_s1 <= op_next;
			case (req.kind)
				KIND_EDGE: begin
					window_left_q  <= win_left_next;
					window_right_q <= win_right_next;
				end
				KIND_TICK: begin
					speed_left_q   <= window_left_q;
					speed_right_q  <= window_right_q;
					sum_left_q     <= sum_left_q + window_left_q;
					sum_right_q    <= sum_right_q + window_right_q;
					window_left_q  <= '0;
					window_right_q <= '0;
				end
				KIND_CLEAR: begin
					window_left_q  <= '0;
					window_right_q <= '0;
					speed_left_q   <= '0;
					speed_right_q  <= '0;
					sum_left_q     <= '0;
					sum_right_q    <= '0;
				end
				default: begin
					// ignored kind: hold everything
				end
			endcase
		end
	end

	assign st.op        = op_s1;
	assign st.vel_left  = speed_left_q;
	assign st.vel_right = speed_right_q;
	assign st.sum_left  = sum_left_q;
	assign st.sum_right = sum_right_q;

	assign clear_req     = en.en1 && req.kind == KIND_CLEAR;
	assign tick_req      = en.en1 && req.kind == KIND_TICK;
	assign idle_edge_req = en.en1 && req.kind == KIND_EDGE && !req.left_edge && !req.right_edge;

	`DQO_ASSERT_NEXT(a_clear_zeroes, clear_req, (sum_left_q | sum_right_q | window_left_q) == '0)
	`DQO_ASSERT_NEXT(a_tick_left, tick_req, window_left_q == '0 && speed_left_q == $past(window_left_q))
	`DQO_ASSERT_NEXT(a_tick_right, tick_req, speed_right_q == $past(window_right_q))
	`DQO_ASSERT_NEXT(a_no_edge_holds, idle_edge_req, $stable(window_left_q) && $stable(window_right_q))

endmodule

// ===== rtl/dqo_dist.sv =====
// Distance pipeline and result register: total sum, gain multiply, halving.
// Depends on dqo_pkg.
`timescale 1ns / 1ps

module dqo_dist
	import dqo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  pipe_en_t            en,
	input  stage_t              st,
	input  logic [15:0]         gain,
	output logic signed [31:0]  speed_left_out,
	output logic signed [31:0]  speed_right_out,
	output logic signed [31:0]  total_left,
	output logic signed [31:0]  total_right,
	output logic signed [47:0]  distance_q16
);

	stage_t             st_s2;
	logic signed [32:0] sum33_s2;
	logic signed [32:0] sum33_next;
	logic signed [49:0] prod;

	logic [31:0]        speed_left_s3;
	logic [31:0]        speed_right_s3;
	logic [31:0]        total_left_s3;
	logic [31:0]        total_right_s3;
	logic [47:0]        dist_q;

	// Totals are added at 33 bits so the sum never wraps
	assign sum33_next = $signed({st.sum_left[31], st.sum_left})
		+ $signed({st.sum_right[31], st.sum_right});

	always_ff @(posedge clk) begin
		if (en.en2) begin
			st_s2    <= st;
			sum33_s2 <= sum33_next;
		end
	end

	assign prod = 50'(sum33_s2) * 50'($signed({1'b0, gain}));

	always_ff @(posedge clk) begin
		if (en.en3) begin
			speed_left_s3  <= st_s2.vel_left;
			speed_right_s3 <= st_s2.vel_right;
			total_left_s3  <= st_s2.sum_left;
			total_right_s3 <= st_s2.sum_right;
		end
	end

	// Arithmetic shift drops the low bit: floor of product / 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
		end else if (en.en3) begin
			case (st_s2.op)
				OP_TICK:  dist_q <= prod[48:1];
				OP_CLEAR: dist_q <= '0;
				default:  dist_q <= dist_q;
			endcase
		end
	end

	assign speed_left_out  = $signed(speed_left_s3);
	assign speed_right_out = $signed(speed_right_s3);
	assign total_left      = $signed(total_left_s3);
	assign total_right     = $signed(total_right_s3);
	assign distance_q16    = $signed(dist_q);

endmodule

// ===== rtl/dual_quadrature_odometer.sv =====
// Dual quadrature odometer, top level: handshake control and gain register.
// out_valid rises once a request has passed the state, sum and result registers.
// Throughput: one request per cycle while the result side keeps taking results.
// A stalled result holds the full stages; requests are still taken while a stage is free.
// Reset clears all counters and distance; the gain resets to 655 (Q0.16).
`timescale 1ns / 1ps

module dual_quadrature_odometer
	import dqo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic               left_edge,
	input  logic               left_phase_a,
	input  logic               left_phase_b,
	input  logic               right_edge,
	input  logic               right_phase_a,
	input  logic               right_phase_b,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        distance_gain,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] speed_left_out,
	output logic signed [31:0] speed_right_out,
	output logic signed [31:0] total_left,
	output logic signed [31:0] total_right,
	output logic signed [47:0] distance_q16
);

	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        adv1;
	logic        adv2;
	logic        adv3;
	logic [15:0] gain_q;
	pipe_en_t    en;
	req_t        req;
	stage_t      st;

	// A stage may load when it is empty or its contents move on
	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign in_ready  = adv1;
	assign cfg_ready = 1'b1;
	assign out_valid = v_s3;

	assign en.en1 = in_valid && adv1;
	assign en.en2 = v_s1 && adv2;
	assign en.en3 = v_s2 && adv3;

	assign req.kind          = kind;
	assign req.left_edge     = left_edge;
	assign req.left_phase_a  = left_phase_a;
	assign req.left_phase_b  = left_phase_b;
	assign req.right_edge    = right_edge;
	assign req.right_phase_a = right_phase_a;
	assign req.right_phase_b = right_phase_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= distance_gain;
		end
	end

	dqo_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.st     (st)
	);

	dqo_dist u_dist (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.st              (st),
		.gain            (gain_q),
		.speed_left_out  (speed_left_out),
		.speed_right_out (speed_right_out),
		.total_left      (total_left),
		.total_right     (total_right),
		.distance_q16    (distance_q16)
	);

endmodule

// ===== tb/tb_dual_quadrature_odometer.sv =====
// Self-checking testbench for dual_quadrature_odometer: directed rows, then random phases.
// Depends on dqo_pkg and the dual_quadrature_odometer RTL; predicts untyped readings in-line, typed rows carry theirs.
`timescale 1ns / 1ps

module tb_dual_quadrature_odometer;
	import dqo_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int RESET_CYCLES = 5;
	localparam int PIPE_LATENCY = 3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PHASE_ITEMS = 306;
	localparam int N_PHASES = 5;
	localparam int N_DIRECTED = 18;
	localparam int HOLD_OFF_CYCLES = 250;

	typedef struct packed {
		logic [31:0] vel_left;
		logic [31:0] vel_right;
		logic [31:0] total_left;
		logic [31:0] total_right;
		logic [47:0] distance;
	} reading_t;

	typedef struct packed {
		req_t     req;
		logic     typed;
		reading_t want;
	} stim_row_t;

	localparam reading_t ZERO_READING = '0;
	localparam reading_t ONE_UP = '{32'd1, 32'd1, 32'd1, 32'd1, 48'd655};
	localparam reading_t TWO_DOWN = '{-32'sd2, -32'sd2, -32'sd1, -32'sd1, -48'sd655};

	// Request fields: kind, left edge/A/B, right edge/A/B
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{'{KIND_IGNORED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, ZERO_READING},
		'{'{KIND_EDGE,    1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1, ZERO_READING},
		'{'{KIND_EDGE,    1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, ZERO_READING},
		'{'{KIND_TICK,    1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1, ONE_UP},
		'{'{KIND_EDGE,    1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, ONE_UP},
		'{'{KIND_EDGE,    1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1, ONE_UP},
		'{'{KIND_TICK,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, TWO_DOWN},
		'{'{KIND_EDGE,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_READING},
		'{'{KIND_EDGE,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, ZERO_READING},
		'{'{KIND_EDGE,    1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, ZERO_READING},
		'{'{KIND_EDGE,    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, ZERO_READING},
		'{'{KIND_TICK,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_READING},
		'{'{KIND_IGNORED, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, ZERO_READING},
		'{'{KIND_TICK,    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, ZERO_READING},
		'{'{KIND_CLEAR,   1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, ZERO_READING},
		'{'{KIND_TICK,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, ZERO_READING},
		'{'{KIND_EDGE,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, ZERO_READING},
		'{'{KIND_TICK,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, ZERO_READING}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         kind = KIND_EDGE;
	logic               left_edge = 1'b0;
	logic               left_phase_a = 1'b0;
	logic               left_phase_b = 1'b0;
	logic               right_edge = 1'b0;
	logic               right_phase_a = 1'b0;
	logic               right_phase_b = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        distance_gain = GAIN_RESET;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] speed_left_out;
	logic signed [31:0] speed_right_out;
	logic signed [31:0] total_left;
	logic signed [31:0] total_right;
	logic signed [47:0] distance_q16;

	// Predicted odometer state
	logic [31:0] odo_win_left = '0;
	logic [31:0] odo_win_right = '0;
	logic [31:0] odo_speed_left = '0;
	logic [31:0] odo_speed_right = '0;
	logic [31:0] odo_total_left = '0;
	logic [31:0] odo_total_right = '0;
	logic [47:0] odo_distance = '0;
	logic [15:0] odo_gain = GAIN_RESET;

	reading_t pending_readings [$];
	int       mismatches = 0;
	bit       sender_burst = 1'b0;

	dual_quadrature_odometer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.left_edge      (left_edge),
		.left_phase_a   (left_phase_a),
		.left_phase_b   (left_phase_b),
		.right_edge     (right_edge),
		.right_phase_a  (right_phase_a),
		.right_phase_b  (right_phase_b),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.distance_gain  (distance_gain),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.speed_left_out (speed_left_out),
		.speed_right_out(speed_right_out),
		.total_left     (total_left),
		.total_right    (total_right),
		.distance_q16   (distance_q16)
	);

	always #5 clk = ~clk;

	function automatic reading_t advance_odometer(req_t r);
		longint pair_sum;
		longint product;
		reading_t res;
		case (r.kind)
			KIND_EDGE: begin
				if (r.left_edge) begin
					odo_win_left = (r.left_phase_a != r.left_phase_b) ?
						odo_win_left - 32'd1 : odo_win_left + 32'd1;
				end
				if (r.right_edge) begin
					odo_win_right = (r.right_phase_a != r.right_phase_b) ?
						odo_win_right + 32'd1 : odo_win_right - 32'd1;
				end
			end
			KIND_TICK: begin
				odo_speed_left = odo_win_left;
				odo_speed_right = odo_win_right;
				odo_win_left = '0;
				odo_win_right = '0;
				odo_total_left = odo_total_left + odo_speed_left;
				odo_total_right = odo_total_right + odo_speed_right;
				// 33-bit sum, times gain, halved toward minus infinity
				pair_sum = longint'($signed(odo_total_left)) + longint'($signed(odo_total_right));
				product = (pair_sum * longint'(odo_gain)) >>> 1;
				odo_distance = product[47:0];
			end
			KIND_CLEAR: begin
				odo_win_left = '0;
				odo_win_right = '0;
				odo_speed_left = '0;
				odo_speed_right = '0;
				odo_total_left = '0;
				odo_total_right = '0;
				odo_distance = '0;
			end
			default: ;
		endcase
		res = '{odo_speed_left, odo_speed_right, odo_total_left, odo_total_right, odo_distance};
		return res;
	endfunction

	// Mostly edges that follow each wheel's direction for the phase, plus noise
	function automatic req_t random_request(bit left_fwd, bit right_fwd);
		req_t r;
		int pick;
		r = 9'($urandom_range(0, 511));
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			r.kind = KIND_EDGE;
		end else if (pick < 94) begin
			r.kind = KIND_TICK;
		end else if (pick < 97) begin
			r.kind = KIND_CLEAR;
		end else begin
			r.kind = KIND_IGNORED;
		end
		if (r.kind == KIND_EDGE && $urandom_range(0, 4) != 0) begin
			r.left_phase_b = left_fwd ? r.left_phase_a : ~r.left_phase_a;
			r.right_phase_b = right_fwd ? ~r.right_phase_a : r.right_phase_a;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic offer_request(req_t r, logic typed, reading_t want);
		int gap;
		reading_t predicted;
		gap = sender_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		left_edge <= r.left_edge;
		left_phase_a <= r.left_phase_a;
		left_phase_b <= r.left_phase_b;
		right_edge <= r.right_edge;
		right_phase_a <= r.right_phase_a;
		right_phase_b <= r.right_phase_b;
		do @(posedge clk); while (!in_ready);
		predicted = advance_odometer(r);
		pending_readings.push_back(typed ? want : predicted);
	endtask

	task automatic write_gain(logic [15:0] value);
		cfg_valid <= 1'b1;
		distance_gain <= value;
		do @(posedge clk); while (!cfg_ready);
		odo_gain = value;
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and let the pipe empty before touching the gain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 1) @(posedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_reading(reading_t got);
		reading_t want;
		if (pending_readings.size() == 0) begin
			$display("%0t: reading with no request pending", $time);
			mismatches++;
		end else begin
			want = pending_readings.pop_front();
			check_field("speed_left_out", $signed(want.vel_left), $signed(got.vel_left));
			check_field("speed_right_out", $signed(want.vel_right), $signed(got.vel_right));
			check_field("total_left", $signed(want.total_left), $signed(got.total_left));
			check_field("total_right", $signed(want.total_right), $signed(got.total_right));
			check_field("distance_q16", $signed(want.distance), $signed(got.distance));
		end
	endtask

	// Receiver: random stalls, steady stretches, and two long hold-offs
	initial begin
		int hold;
		int seen;
		bit steady;
		reading_t got;
		hold = 0;
		seen = 0;
		steady = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{speed_left_out, speed_right_out, total_left, total_right, distance_q16};
				compare_reading(got);
				seen++;
				if (seen == 300 || seen == 1100) hold = HOLD_OFF_CYCLES;
			end
			if ($urandom_range(0, 127) == 0) steady = ~steady;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (steady || $urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("dual_quadrature_odometer test failed");
		$finish;
	end

	initial begin
		logic [15:0] next_gain;
		bit left_fwd;
		bit right_fwd;
		int drained;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at the reset gain
		for (int i = 0; i < N_DIRECTED; i++) begin
			offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: next_gain = 16'hFFFF;
				1: next_gain = 16'h0000;
				2: next_gain = 16'h0001;
				default: next_gain = 16'($urandom_range(0, 65535));
			endcase
			write_gain(next_gain);
			left_fwd = 1'($urandom_range(0, 1));
			right_fwd = 1'($urandom_range(0, 1));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
				offer_request(random_request(left_fwd, right_fwd), 1'b0, ZERO_READING);
			end
		end

		in_valid <= 1'b0;
		drained = 0;
		while (pending_readings.size() != 0 && drained < DRAIN_LIMIT) begin
			@(posedge clk);
			drained++;
		end
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (pending_readings.size() != 0) begin
			$display("%0t: %0d readings never arrived", $time, pending_readings.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("dual_quadrature_odometer test passed");
		end else begin
			$display("dual_quadrature_odometer test failed");
		end
		$finish;
	end

endmodule
